// ===== design/vr_pkg.sv =====
// vr_pkg: shared types, constants and the saturation helper for the refraction pipeline
// depends on nothing; imported by every vr_* module and by vector_refract_core
package vr_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int CW            = 20;
  localparam int RATW          = 18;

  localparam logic signed [CW-1:0] CMP_MAX = 20'sh7FFFF;
  localparam logic signed [CW-1:0] CMP_MIN = -20'sh80000;

  // one ray as it travels down the pipeline
  typedef struct packed {
    logic [2:0][CW-1:0] v;
    logic [2:0][CW-1:0] n;
    logic [RATW-1:0]    ratio;
    logic [2:0][CW-1:0] perp;
    logic [CW-1:0]      s;
    logic               hit;
  } ray_t;

  typedef struct packed {
    logic                 hit;
    logic signed [CW-1:0] val;
  } sat_t;

  // clamp to the signed component range
  function automatic sat_t sat20(input logic signed [63:0] v);
    sat_t r;
    if (v > 64'(CMP_MAX)) begin
      r.hit = 1'b1;
      r.val = CMP_MAX;
    end else if (v < 64'(CMP_MIN)) begin
      r.hit = 1'b1;
      r.val = CMP_MIN;
    end else begin
      r.hit = 1'b0;
      r.val = v[CW-1:0];
    end
    return r;
  endfunction

endpackage

// ===== design/vr_front.sv =====
// vr_front: cosine term and perpendicular component, six register stages
// depends on vr_pkg
module vr_front import vr_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_stall,
  input  ray_t in_ray,
  output logic out_valid,
  input  logic out_stall,
  output ray_t out_ray
);

  localparam int NST = 6;
  localparam logic signed [42:0] HALF43 = 43'sd1 <<< (FRAC_BITS - 1);
  localparam logic signed [42:0] ONE43  = 43'sd1 <<< FRAC_BITS;
  localparam logic signed [40:0] HALF41 = 41'sd1 <<< (FRAC_BITS - 1);
  localparam logic signed [39:0] HALF40 = 40'sd1 <<< (FRAC_BITS - 1);

  logic [NST-1:0] vld;
  logic [NST:0]   ce;
  ray_t           ray    [NST];
  ray_t           ray_nx [NST];

  logic signed [39:0]   p0 [3];
  logic signed [CW-1:0] cos1;
  logic signed [39:0]   q2 [3];
  logic signed [CW-1:0] t3 [3];
  logic signed [38:0]   u4 [3];

  logic signed [39:0]   p0_next [3];
  logic signed [CW-1:0] cos1_next;
  logic signed [39:0]   q2_next [3];
  logic signed [CW-1:0] t3_next [3];
  logic signed [38:0]   u4_next [3];

  // stage enables: a stage moves when empty or when the next one moves
  always_comb begin
    ce[NST] = !out_stall;
    for (int i = NST - 1; i >= 0; i--) ce[i] = !vld[i] || ce[i+1];
  end

  assign in_stall  = !ce[0];
  assign out_valid = vld[NST-1];
  assign out_ray   = ray[NST-1];

  // stage arithmetic
  always_comb begin
    logic signed [41:0] dot;
    logic signed [42:0] nd;
    logic signed [42:0] rc;
    logic signed [40:0] rq;
    logic signed [39:0] ru;
    sat_t               sc;
    sat_t               st;
    sat_t               sp;

    ray_nx[0] = in_ray;
    for (int i = 1; i < NST; i++) ray_nx[i] = ray[i-1];

    // products of incident and normal
    for (int j = 0; j < 3; j++)
      p0_next[j] = 40'($signed(in_ray.v[j])) * 40'($signed(in_ray.n[j]));

    // cos = min(round(-dot), one), clamped
    dot = 42'(p0[0]) + 42'(p0[1]) + 42'(p0[2]);
    nd  = -43'(dot);
    rc  = (nd + HALF43) >>> FRAC_BITS;
    if (rc > ONE43) rc = ONE43;
    sc        = sat20(64'(rc));
    cos1_next = sc.val;
    ray_nx[1].hit = ray[0].hit | sc.hit;

    // normal times cos
    for (int j = 0; j < 3; j++)
      q2_next[j] = 40'($signed(ray[1].n[j])) * 40'(cos1);

    // in + n*cos
    ray_nx[3].hit = ray[2].hit;
    for (int j = 0; j < 3; j++) begin
      rq = (41'(q2[j]) + HALF41) >>> FRAC_BITS;
      st = sat20(64'(rq) + 64'($signed(ray[2].v[j])));
      t3_next[j] = st.val;
      ray_nx[3].hit = ray_nx[3].hit | st.hit;
    end

    // scale by ratio
    for (int j = 0; j < 3; j++)
      u4_next[j] = 39'(t3[j]) * 39'($signed({1'b0, ray[3].ratio}));

    // perp, rounded and clamped
    ray_nx[5].hit = ray[4].hit;
    for (int j = 0; j < 3; j++) begin
      ru = (40'(u4[j]) + HALF40) >>> FRAC_BITS;
      sp = sat20(64'(ru));
      ray_nx[5].perp[j] = sp.val;
      ray_nx[5].hit = ray_nx[5].hit | sp.hit;
    end
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (ce[0]) vld[0] <= in_valid;
      for (int i = 1; i < NST; i++) if (ce[i]) vld[i] <= vld[i-1];
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    for (int i = 0; i < NST; i++) if (ce[i]) ray[i] <= ray_nx[i];
    if (ce[0]) p0 <= p0_next;
    if (ce[1]) cos1 <= cos1_next;
    if (ce[2]) q2 <= q2_next;
    if (ce[3]) t3 <= t3_next;
    if (ce[4]) u4 <= u4_next;
  end

endmodule

// ===== design/vr_sqrt.sv =====
// vr_sqrt: squared length of perp, |one^2 - len^2| and its floor square root,
// two root bits per stage; depends on vr_pkg
module vr_sqrt import vr_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_stall,
  input  ray_t in_ray,
  output logic out_valid,
  input  logic out_stall,
  output ray_t out_ray
);

  localparam int DW  = (2 * FRAC_BITS + 2 > 44) ? 2 * FRAC_BITS + 2 : 44;
  localparam int RW  = DW / 2;
  localparam int NS  = (RW + 1) / 2;
  localparam int NST = NS + 3;
  localparam logic signed [DW-1:0] ONE2 = DW'(1) <<< (2 * FRAC_BITS);

  logic [NST-1:0] vld;
  logic [NST:0]   ce;
  ray_t           ray    [NST];
  ray_t           ray_nx [NST];

  logic signed [39:0] sq      [3];
  logic signed [39:0] sq_next [3];
  logic [DW-1:0]      xs      [NS+1];
  logic [RW:0]        rem     [NS+1];
  logic [RW-1:0]      root    [NS+1];
  logic [DW-1:0]      xs_next   [NS+1];
  logic [RW:0]        rem_next  [NS+1];
  logic [RW-1:0]      root_next [NS+1];

  always_comb begin
    ce[NST] = !out_stall;
    for (int i = NST - 1; i >= 0; i--) ce[i] = !vld[i] || ce[i+1];
  end

  assign in_stall  = !ce[0];
  assign out_valid = vld[NST-1];
  assign out_ray   = ray[NST-1];

  always_comb begin
    logic signed [41:0]   lsq;
    logic signed [DW-1:0] diff;
    logic [DW-1:0]        x;
    logic [RW:0]          r;
    logic [RW-1:0]        q;
    logic [RW+2:0]        remn;
    logic [RW+2:0]        trial;
    sat_t                 ss;

    ray_nx[0] = in_ray;
    for (int i = 1; i < NST; i++) ray_nx[i] = ray[i-1];

    // squares of perp
    for (int j = 0; j < 3; j++)
      sq_next[j] = 40'($signed(in_ray.perp[j])) * 40'($signed(in_ray.perp[j]));

    // magnitude under the root
    lsq  = 42'(sq[0]) + 42'(sq[1]) + 42'(sq[2]);
    diff = ONE2 - DW'(lsq);
    xs_next[0]   = (diff < 0) ? DW'(-diff) : DW'(diff);
    rem_next[0]  = '0;
    root_next[0] = '0;

    // digit recurrence, two steps per stage
    for (int k = 1; k <= NS; k++) begin
      x = xs[k-1];
      r = rem[k-1];
      q = root[k-1];
      for (int st = 0; st < 2; st++) begin
        if ((k - 1) * 2 + st < RW) begin
          remn  = {r, x[DW-1:DW-2]};
          trial = {1'b0, q, 2'b01};
          x     = x << 2;
          if (remn >= trial) begin
            remn = remn - trial;
            q    = {q[RW-2:0], 1'b1};
          end else begin
            q    = {q[RW-2:0], 1'b0};
          end
          r = remn[RW:0];
        end
      end
      xs_next[k]   = x;
      rem_next[k]  = r;
      root_next[k] = q;
    end

    // clamp the root
    ss = sat20(64'(root[NS]));
    ray_nx[NST-1].s   = ss.val;
    ray_nx[NST-1].hit = ray[NST-2].hit | ss.hit;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (ce[0]) vld[0] <= in_valid;
      for (int i = 1; i < NST; i++) if (ce[i]) vld[i] <= vld[i-1];
    end
  end

  // stage k of the root sits at pipeline stage k+1
  always_ff @(posedge clk) begin
    for (int i = 0; i < NST; i++) if (ce[i]) ray[i] <= ray_nx[i];
    if (ce[0]) sq <= sq_next;
    for (int k = 0; k <= NS; k++) begin
      if (ce[k+1]) begin
        xs[k]   <= xs_next[k];
        rem[k]  <= rem_next[k];
        root[k] <= root_next[k];
      end
    end
  end

endmodule

// ===== design/vr_back.sv =====
// vr_back: parallel term -n*s and the final sum, ending in the output register
// depends on vr_pkg
module vr_back import vr_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  ray_t                 in_ray,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic signed [CW-1:0] out_x,
  output logic signed [CW-1:0] out_y,
  output logic signed [CW-1:0] out_z,
  output logic                 clipped
);

  localparam logic signed [40:0] HALF41 = 41'sd1 <<< (FRAC_BITS - 1);

  logic [1:0] vld;
  logic [2:0] ce;
  ray_t       ray0;

  logic signed [39:0]   m      [3];
  logic signed [39:0]   m_next [3];
  logic signed [CW-1:0] res      [3];
  logic signed [CW-1:0] res_next [3];
  logic                 hit_next;

  always_comb begin
    ce[2] = !out_stall;
    for (int i = 1; i >= 0; i--) ce[i] = !vld[i] || ce[i+1];
  end

  assign in_stall  = !ce[0];
  assign out_valid = vld[1];
  assign out_x     = res[0];
  assign out_y     = res[1];
  assign out_z     = res[2];

  always_comb begin
    logic signed [40:0] rp;
    sat_t               sp;
    sat_t               so;

    // normal times root
    for (int j = 0; j < 3; j++)
      m_next[j] = 40'($signed(in_ray.n[j])) * 40'($signed(in_ray.s));

    // par = round(-n*s), then perp + par
    hit_next = ray0.hit;
    for (int j = 0; j < 3; j++) begin
      rp = (-41'(m[j]) + HALF41) >>> FRAC_BITS;
      sp = sat20(64'(rp));
      so = sat20(64'(sp.val) + 64'($signed(ray0.perp[j])));
      res_next[j] = so.val;
      hit_next = hit_next | sp.hit | so.hit;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (ce[0]) vld[0] <= in_valid;
      if (ce[1]) vld[1] <= vld[0];
    end
  end

  always_ff @(posedge clk) begin
    if (ce[0]) begin
      ray0 <= in_ray;
      m    <= m_next;
    end
    if (ce[1]) begin
      res     <= res_next;
      clipped <= hit_next;
    end
  end

endmodule

// ===== design/vector_refract_core.sv =====
// Snell refraction of a direction through a surface, Q3.FRAC_BITS components, saturating.
// One ray enters per clock when the output side is not stalled. vr_sqrt holds NS root
// stages, NS being (max(FRAC_BITS+1, 22)+1)/2, with two root bits each.
// Bubbles in the pipe are squeezed out while the output is stalled.
// Total internal reflection is not flagged; clipped marks any saturation along the way.
// depends on vr_pkg, vr_front, vr_sqrt, vr_back
module vector_refract_core import vr_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic signed [CW-1:0]   in_x,
  input  logic signed [CW-1:0]   in_y,
  input  logic signed [CW-1:0]   in_z,
  input  logic signed [CW-1:0]   nrm_x,
  input  logic signed [CW-1:0]   nrm_y,
  input  logic signed [CW-1:0]   nrm_z,
  input  logic        [RATW-1:0] ratio,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic signed [CW-1:0]   out_x,
  output logic signed [CW-1:0]   out_y,
  output logic signed [CW-1:0]   out_z,
  output logic                   clipped
);

  ray_t ray_in;
  ray_t ray_f;
  ray_t ray_s;
  logic f_valid;
  logic f_stall;
  logic s_valid;
  logic s_stall;

  // pack the input beat
  always_comb begin
    ray_in       = '0;
    ray_in.v[0]  = in_x;
    ray_in.v[1]  = in_y;
    ray_in.v[2]  = in_z;
    ray_in.n[0]  = nrm_x;
    ray_in.n[1]  = nrm_y;
    ray_in.n[2]  = nrm_z;
    ray_in.ratio = ratio;
  end

  vr_front #(.FRAC_BITS(FRAC_BITS)) u_front (
    .clk, .rst,
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_ray    (ray_in),
    .out_valid (f_valid),
    .out_stall (f_stall),
    .out_ray   (ray_f)
  );

  vr_sqrt #(.FRAC_BITS(FRAC_BITS)) u_sqrt (
    .clk, .rst,
    .in_valid  (f_valid),
    .in_stall  (f_stall),
    .in_ray    (ray_f),
    .out_valid (s_valid),
    .out_stall (s_stall),
    .out_ray   (ray_s)
  );

  vr_back #(.FRAC_BITS(FRAC_BITS)) u_back (
    .clk, .rst,
    .in_valid  (s_valid),
    .in_stall  (s_stall),
    .in_ray    (ray_s),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_x, .out_y, .out_z, .clipped
  );

  // an empty output register or a free output side never blocks the input
  a_empty_accepts: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> !in_stall) else $error("input stalled with empty output");
  a_free_accepts: assert property (@(posedge clk) disable iff (rst)
    !out_stall |-> !in_stall) else $error("input stalled with free output");
  a_inner_flow: assert property (@(posedge clk) disable iff (rst)
    s_valid && !s_stall && out_valid && out_stall |=> out_valid)
    else $error("result lost in the back stage");

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 100ps
// tb: self-checking bench for vector_refract_core (fixed-point Snell refraction)
// depends on vr_pkg and the vector_refract_core RTL; directed table then random rays
module tb import vr_pkg::*; ();

  localparam int FB        = 16;
  localparam int N_RANDOM  = 1350;
  localparam int WDOG_MAX  = 5000;
  localparam int DRAIN_CYC = 40;

  typedef struct {
    logic signed [CW-1:0] x, y, z;
    logic                 clipped;
  } refr_t;

  typedef struct {
    logic signed [CW-1:0] ix, iy, iz, nx, ny, nz;
    logic [RATW-1:0]      rt;
    bit                   typed;
    refr_t                res;
  } ray_row_t;

  logic clk, rst;
  logic in_valid, in_stall, out_valid, out_stall;
  logic signed [CW-1:0] in_x, in_y, in_z, nrm_x, nrm_y, nrm_z;
  logic [RATW-1:0] ratio;
  logic signed [CW-1:0] out_x, out_y, out_z;
  logic clipped;

  refr_t expected_q[$];
  int errors = 0;
  int rays_sent = 0, rays_seen = 0, clip_seen = 0;
  int idle_cnt = 0;
  bit calm = 0;
  int in_gap = 0, out_gap = 0;

  vector_refract_core u_top (.*);

  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  // round to nearest, ties up
  function automatic longint rnd_q(longint v);
    longint y;
    y = v + (64'sd1 <<< (FB - 1));
    return y >>> FB;
  endfunction

  function automatic longint clamp_c(longint v, inout bit hit);
    if (v > 524287) begin
      hit = 1;
      return 524287;
    end
    if (v < -524288) begin
      hit = 1;
      return -524288;
    end
    return v;
  endfunction

  function automatic longint floor_sqrt(longint unsigned x);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > x) b >>= 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return longint'(r);
  endfunction

  // refracted direction for one ray
  function automatic refr_t refract(logic signed [CW-1:0] ix, iy, iz, nx, ny, nz,
                                    logic [RATW-1:0] rt);
    longint v[3], n[3], perp[3], dot, cs, lsq, diff, s, t, par;
    longint unsigned mag;
    bit hit;
    refr_t r;
    v = '{ix, iy, iz};
    n = '{nx, ny, nz};
    hit = 0;
    dot = 0;
    lsq = 0;
    for (int i = 0; i < 3; i++) dot += v[i] * n[i];
    cs = rnd_q(-dot);
    if (cs > (64'sd1 <<< FB)) cs = 64'sd1 <<< FB;
    cs = clamp_c(cs, hit);
    for (int i = 0; i < 3; i++) begin
      t = clamp_c(v[i] + rnd_q(n[i] * cs), hit);
      perp[i] = clamp_c(rnd_q(t * longint'(rt)), hit);
      lsq += perp[i] * perp[i];
    end
    diff = (64'sd1 <<< (2 * FB)) - lsq;
    mag = diff < 0 ? -diff : diff;
    s = clamp_c(floor_sqrt(mag), hit);
    for (int i = 0; i < 3; i++) begin
      par = clamp_c(rnd_q(-(n[i] * s)), hit);
      perp[i] = clamp_c(perp[i] + par, hit);
    end
    r.x = CW'(perp[0]);
    r.y = CW'(perp[1]);
    r.z = CW'(perp[2]);
    r.clipped = hit;
    return r;
  endfunction

  // directed rays: zero, unit normal incidence, extremes, saturation
  ray_row_t dir_tab[$];
  initial begin
    dir_tab = '{
      '{0, 0, 0, 0, 0, 0, 0, 1, '{0, 0, 0, 0}},
      '{0, 0, -65536, 0, 0, 65536, 65536, 1, '{0, 0, -65536, 0}},
      '{0, 0, -65536, 0, 0, 65536, 0, 1, '{0, 0, -65536, 0}},
      '{65536, 0, 0, 0, 0, 65536, 65536, 0, '{0, 0, 0, 0}},
      '{46341, 0, -46341, 0, 0, 65536, 98304, 0, '{0, 0, 0, 0}},
      '{46341, 0, -46341, 0, 0, 65536, 49152, 0, '{0, 0, 0, 0}},
      '{-524288, -524288, -524288, -524288, -524288, -524288, 262143, 0, '{0, 0, 0, 0}},
      '{524287, 524287, 524287, 524287, 524287, 524287, 262143, 0, '{0, 0, 0, 0}},
      '{524287, -524288, 524287, -524288, 524287, -524288, 262143, 0, '{0, 0, 0, 0}},
      '{-524288, 0, 0, 524287, 0, 0, 1, 0, '{0, 0, 0, 0}},
      '{524287, 524287, 524287, 0, 0, 0, 262143, 0, '{0, 0, 0, 0}},
      '{0, 0, 0, 524287, 524287, 524287, 0, 0, '{0, 0, 0, 0}},
      '{1, -1, 1, -1, 1, -1, 131072, 0, '{0, 0, 0, 0}},
      '{32768, 32768, -32768, 0, 65536, 0, 65536, 0, '{0, 0, 0, 0}}
    };
  end

  // expected results are checked in arrival order
  always @(posedge clk) begin
    refr_t e;
    if (!rst && out_valid && !out_stall) begin
      rays_seen++;
      if (expected_q.size() == 0) begin
        $error("unexpected beat: out_x %0d", out_x);
        errors++;
      end else begin
        e = expected_q.pop_front();
        if (out_x !== e.x) begin $error("out_x exp %0d got %0d", e.x, out_x); errors++; end
        if (out_y !== e.y) begin $error("out_y exp %0d got %0d", e.y, out_y); errors++; end
        if (out_z !== e.z) begin $error("out_z exp %0d got %0d", e.z, out_z); errors++; end
        if (clipped !== e.clipped) begin
          $error("clipped exp %0b got %0b", e.clipped, clipped);
          errors++;
        end
        if (clipped === 1'b1) clip_seen++;
      end
    end
  end

  // receiver stall bursts
  always @(posedge clk) begin
    if (rst || calm) begin
      out_stall <= 0;
      out_gap <= 0;
    end else if (out_gap > 0) begin
      out_gap <= out_gap - 1;
      out_stall <= (out_gap > 1);
    end else if ($urandom_range(0, 9) == 0) begin
      out_gap <= $urandom_range(1, 16);
      out_stall <= 1;
    end else begin
      out_stall <= 0;
    end
  end

  // watchdog on cycles with no accepted beat
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) idle_cnt <= 0;
    else idle_cnt <= idle_cnt + 1;
    if (idle_cnt >= WDOG_MAX) begin
      $display("watchdog expired");
      $display("vector_refract_core: mismatch");
      $finish;
    end
  end

  // pick a random component, mostly unit-ish, sometimes full range
  function automatic logic signed [CW-1:0] rand_comp();
    if ($urandom_range(0, 3) == 0) return CW'($urandom);
    return CW'($signed($urandom_range(0, 131072)) - 65536);
  endfunction

  task automatic send_ray(ray_row_t r);
    refr_t e;
    if (!calm && $urandom_range(0, 7) == 0) begin
      in_valid <= 0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
    in_valid <= 1;
    in_x <= r.ix; in_y <= r.iy; in_z <= r.iz;
    nrm_x <= r.nx; nrm_y <= r.ny; nrm_z <= r.nz;
    ratio <= r.rt;
    e = r.typed ? r.res : refract(r.ix, r.iy, r.iz, r.nx, r.ny, r.nz, r.rt);
    do @(posedge clk); while (in_stall);
    expected_q.push_back(e);
    rays_sent++;
  endtask

  initial begin
    ray_row_t r;
    int waited;
    rst = 1;
    in_valid = 0;
    in_x = 0; in_y = 0; in_z = 0;
    nrm_x = 0; nrm_y = 0; nrm_z = 0;
    ratio = 0;
    repeat (9) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    foreach (dir_tab[i]) send_ray(dir_tab[i]);
    for (int k = 0; k < N_RANDOM; k++) begin
      if (k == N_RANDOM - 150) calm = 1;
      r.ix = rand_comp(); r.iy = rand_comp(); r.iz = rand_comp();
      r.nx = rand_comp(); r.ny = rand_comp(); r.nz = rand_comp();
      r.rt = ($urandom_range(0, 4) == 0) ? RATW'($urandom)
                                         : RATW'($urandom_range(32768, 98304));
      r.typed = 0;
      send_ray(r);
    end
    in_valid <= 0;
    waited = 0;
    while (expected_q.size() != 0 && waited < 20000) begin
      @(posedge clk);
      waited++;
    end
    repeat (DRAIN_CYC) @(posedge clk);
    if (expected_q.size() != 0) begin
      $error("%0d results never arrived", expected_q.size());
      errors++;
    end
    $display("rays sent %0d, results checked %0d, %0d with saturation",
             rays_sent, rays_seen, clip_seen);
    if (errors == 0) $display("vector_refract_core: match");
    else $display("vector_refract_core: mismatch");
    $finish;
  end
endmodule

// ===== sim.f =====
design/vr_pkg.sv
design/vr_front.sv
design/vr_sqrt.sv
design/vr_back.sv
design/vector_refract_core.sv
verif/tb.sv
